@@ hw/rtl/dpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Debounced pulse counter package
// Field widths, register indexes and stream packing shared by the block.
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int STAMP_IN_W = 32;
  localparam int PIN_W      = 4;
  localparam int COUNT_W    = 32;
  localparam int OUT_COUNTS = 4;
  localparam int LIVE_W     = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int S_DATA_W   = 40;
  localparam int M_DATA_W   = 136;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_CHANNELS = 3'd0,
    CFG_STABLE_TICKS_0  = 3'd1,
    CFG_STABLE_TICKS_1  = 3'd2,
    CFG_STABLE_TICKS_2  = 3'd3,
    CFG_STABLE_TICKS_3  = 3'd4
  } cfg_index_t;

endpackage

@@ hw/rtl/dpc_channel.sv @@
// ----------------------------------------------------------------------------
// Debounced pulse counter channel
// Debounce state and rising-edge counter of one input pin.
// ----------------------------------------------------------------------------
module dpc_channel #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            level,
  input  logic [TIME_BITS-1:0]            now,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]  stable_ticks,
  output logic [dpc_pkg::COUNT_W-1:0]     count_after
);
  import dpc_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

  logic                 seen_level;
  logic [TIME_BITS-1:0] change_stamp;
  logic                 settled_level;
  logic [COUNT_W-1:0]   pulse_count;

  logic [TIME_BITS-1:0]            elapsed;
  logic [TIME_BITS+CFG_DATA_W-1:0] elapsed_wide;
  logic [TIME_BITS+CFG_DATA_W-1:0] ticks_wide;
  logic                            settle;
  logic                            rise;

  assign elapsed      = now - change_stamp;
  assign elapsed_wide = {{CFG_DATA_W{1'b0}}, elapsed};
  assign ticks_wide   = {{TIME_BITS{1'b0}}, stable_ticks};
  assign settle = (stable_ticks == '0) ||
                  ((level == seen_level) &&
                   (elapsed_wide[CMP_W-1:0] > ticks_wide[CMP_W-1:0]));
  assign rise        = settle && level && !settled_level;
  assign count_after = rise ? pulse_count + COUNT_W'(1) : pulse_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_level    <= 1'b0;
      change_stamp  <= '0;
      settled_level <= 1'b0;
      pulse_count   <= '0;
    end else if (step) begin
      if (settle) begin
        settled_level <= level;
        pulse_count   <= count_after;
      end else if (level != seen_level) begin
        seen_level   <= level;
        change_stamp <= now;
      end
    end
  end

endmodule

@@ hw/rtl/debounced_pulse_counter_unit.sv @@
// ----------------------------------------------------------------------------
// Debounced pulse counter
// Multichannel pin debouncer with wrapping rising-edge counters per channel.
// ----------------------------------------------------------------------------
// A sample passes the input register, then the result register; a stall on m_tready can hold it between them.
// Throughput: one item per cycle while m_tready does not stall; the per-channel subtract, compare and
// increment sit in the single stage between input and result registers.
// Reset (rst, synchronous) clears configuration, all channel state and both
// stage valid flags.
module debounced_pulse_counter_unit #(
  parameter int CHANNELS  = 4,
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // now_ticks[31:0], pin_levels[35:32], zero pad
  input  logic [dpc_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // count_0..count_3 at [31:0]..[127:96], channels_present[130:128], zero pad
  output logic [dpc_pkg::M_DATA_W-1:0]   m_tdata
);
  import dpc_pkg::*;

  logic [LIVE_W-1:0]     active_channels;
  logic [CFG_DATA_W-1:0] stable_ticks [CHANNELS];

  logic                  in_valid;
  logic [STAMP_IN_W-1:0] in_now;
  logic [PIN_W-1:0]      in_pins;

  logic                  out_valid;
  logic [COUNT_W-1:0]    out_count [OUT_COUNTS];
  logic [LIVE_W-1:0]     out_present;

  logic                            advance;
  logic [LIVE_W:0]                 live_wide;
  logic [LIVE_W-1:0]               live;
  logic [TIME_BITS+STAMP_IN_W-1:0] now_wide;
  logic [TIME_BITS-1:0]            now;
  logic [COUNT_W-1:0]              count_after [CHANNELS];

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  assign live_wide = {1'b0, active_channels};
  assign live = (live_wide > (LIVE_W+1)'(CHANNELS)) ? LIVE_W'(CHANNELS) : active_channels;

  assign now_wide = {{TIME_BITS{1'b0}}, in_now};
  assign now      = now_wide[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= '0;
    end else if (cfg_we && cfg_index == CFG_ACTIVE_CHANNELS) begin
      active_channels <= cfg_data[LIVE_W-1:0];
    end
  end

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    logic level;
    logic step;

    if (ch < OUT_COUNTS) begin : g_cfg
      always_ff @(posedge clk) begin
        if (rst) begin
          stable_ticks[ch] <= '0;
        end else if (cfg_we &&
                     cfg_index == CFG_IDX_W'(int'(CFG_STABLE_TICKS_0) + ch)) begin
          stable_ticks[ch] <= cfg_data;
        end
      end
    end else begin : g_nocfg
      assign stable_ticks[ch] = '0;
    end

    if (ch < PIN_W) begin : g_pin
      assign level = in_pins[ch];
    end else begin : g_nopin
      assign level = 1'b0;
    end

    assign step = advance && ((LIVE_W+1)'(ch) < {1'b0, live});

    dpc_channel #(
      .TIME_BITS(TIME_BITS)
    ) u_channel (
      .clk          (clk),
      .rst          (rst),
      .step         (step),
      .level        (level),
      .now          (now),
      .stable_ticks (stable_ticks[ch]),
      .count_after  (count_after[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now  <= s_tdata[STAMP_IN_W-1:0];
      in_pins <= s_tdata[STAMP_IN_W +: PIN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  for (genvar i = 0; i < OUT_COUNTS; i++) begin : g_out
    if (i < CHANNELS) begin : g_live
      always_ff @(posedge clk) begin
        if (advance) begin
          out_count[i] <= ((LIVE_W+1)'(i) < {1'b0, live}) ? count_after[i] : '0;
        end
      end
    end else begin : g_absent
      assign out_count[i] = '0;
    end
    assign m_tdata[i*COUNT_W +: COUNT_W] = out_count[i];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_present <= live;
    end
  end

  assign m_tdata[OUT_COUNTS*COUNT_W +: LIVE_W] = out_present;
  assign m_tdata[M_DATA_W-1:OUT_COUNTS*COUNT_W+LIVE_W] = '0;
  assign m_tvalid = out_valid;

endmodule

@@ hw/rtl/dpc_checker.sv @@
// ----------------------------------------------------------------------------
// Debounced pulse counter checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dpc_checker #(
  parameter int CHANNELS = 4
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [dpc_pkg::M_DATA_W-1:0] m_tdata
);
  import dpc_pkg::*;

  logic [LIVE_W-1:0]  present;
  logic [COUNT_W-1:0] count_0;
  logic               have_prev;
  logic [LIVE_W-1:0]  prev_present;
  logic [COUNT_W-1:0] prev_count_0;

  assign present = m_tdata[OUT_COUNTS*COUNT_W +: LIVE_W];
  assign count_0 = m_tdata[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      prev_present <= present;
      prev_count_0 <= count_0;
    end
  end

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_present_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, present} <= (LIVE_W+1)'(CHANNELS)))
    else $error("channels_present above channel count");

  a_idle_counts_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((present > 3'd0 || m_tdata[31:0] == '0) &&
                  (present > 3'd1 || m_tdata[63:32] == '0) &&
                  (present > 3'd2 || m_tdata[95:64] == '0) &&
                  (present > 3'd3 || m_tdata[127:96] == '0)))
    else $error("count of an inactive channel is not zero");

  a_count_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && have_prev && present == prev_present && present != '0)
      |-> (count_0 == prev_count_0 || count_0 == prev_count_0 + COUNT_W'(1)))
    else $error("channel zero count moved by more than one");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind debounced_pulse_counter_unit dpc_checker #(
  .CHANNELS(CHANNELS)
) u_dpc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Debounced pulse counter testbench
// Streams time-stamped pin samples into the unit under random idling on both
// sides and checks every count word against a cycle-free debounce predictor.
// The configuration is reprogrammed between phases, only once the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import dpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNMAPPED  = 3'd7;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_SAMPLES = 90;

  // packed from the top bit down: pins above the time stamp, as on tdata
  typedef struct packed {
    logic [PIN_W-1:0]      pins;
    logic [STAMP_IN_W-1:0] now;
  } sample_t;

  typedef struct packed {
    logic [OUT_COUNTS-1:0][COUNT_W-1:0] cnt;
    logic [LIVE_W-1:0]                  present;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;

  // predictor state and configuration
  logic [LIVE_W-1:0]     live_cfg;
  logic [COUNT_W-1:0]    hold_ticks [OUT_COUNTS];
  logic                  seen_lvl   [OUT_COUNTS];
  logic [STAMP_IN_W-1:0] seen_stamp [OUT_COUNTS];
  logic                  steady_lvl [OUT_COUNTS];
  logic [COUNT_W-1:0]    edge_cnt   [OUT_COUNTS];

  sample_t     sample_q [$];
  tally_t      tally_q  [$];
  int unsigned n_pushed = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_phases = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  logic        in_taken = 1'b0;
  logic        flat_out = 1'b0;

  debounced_pulse_counter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic flag(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic count_pulses(input sample_t smp);
    tally_t            exp;
    int unsigned       live;
    logic              lvl;
    logic [STAMP_IN_W-1:0] elapsed;
    logic              settle;
    live = (live_cfg > OUT_COUNTS) ? OUT_COUNTS : live_cfg;
    for (int i = 0; i < OUT_COUNTS; i++) begin
      if (i < live) begin
        lvl = smp.pins[i];
        elapsed = smp.now - seen_stamp[i];
        settle = (hold_ticks[i] == '0) ||
                 (lvl == seen_lvl[i] && elapsed > hold_ticks[i]);
        if (settle) begin
          if (lvl && !steady_lvl[i]) edge_cnt[i] = edge_cnt[i] + 1'b1;
          steady_lvl[i] = lvl;
        end else if (lvl != seen_lvl[i]) begin
          seen_lvl[i] = lvl;
          seen_stamp[i] = smp.now;
        end
      end
      exp.cnt[i] = (i < live) ? edge_cnt[i] : '0;
    end
    exp.present = LIVE_W'(live);
    tally_q.push_back(exp);
  endtask

  // input side: a fresh sample after each transfer, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
    end else if (in_gap > 0) begin
      s_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (sample_q.size() > 0) begin
      s_tdata <= S_DATA_W'(sample_q.pop_front());
      s_tvalid <= 1'b1;
      in_gap <= flat_out ? 0 : pick_gap();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (out_hold > 0) begin
      m_tready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      m_tready <= 1'b1;
      out_hold <= flat_out ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    tally_t want;
    sample_t smp;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (tally_q.size() == 0) begin
        flag($sformatf("result %h with nothing pending", m_tdata));
      end else begin
        want = tally_q.pop_front();
        for (int i = 0; i < OUT_COUNTS; i++)
          if (m_tdata[i*COUNT_W +: COUNT_W] !== want.cnt[i])
            flag($sformatf("count_%0d got %h want %h", i,
                           m_tdata[i*COUNT_W +: COUNT_W], want.cnt[i]));
        if (m_tdata[OUT_COUNTS*COUNT_W +: LIVE_W] !== want.present)
          flag($sformatf("channels_present got %0d want %0d",
                         m_tdata[OUT_COUNTS*COUNT_W +: LIVE_W], want.present));
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      smp.now  = s_tdata[STAMP_IN_W-1:0];
      smp.pins = s_tdata[STAMP_IN_W +: PIN_W];
      count_pulses(smp);
      n_accepted++;
    end
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d samples in, %0d results out", n_accepted, n_results);
    $display("FAIL debounced_pulse_counter_unit");
    $finish;
  end

  task automatic push_sample(input logic [STAMP_IN_W-1:0] now,
                             input logic [PIN_W-1:0] pins);
    sample_t smp;
    smp.now = now;
    smp.pins = pins;
    sample_q.push_back(smp);
    n_pushed++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ACTIVE_CHANNELS: live_cfg = val[LIVE_W-1:0];
      CFG_STABLE_TICKS_0:  hold_ticks[0] = val;
      CFG_STABLE_TICKS_1:  hold_ticks[1] = val;
      CFG_STABLE_TICKS_2:  hold_ticks[2] = val;
      CFG_STABLE_TICKS_3:  hold_ticks[3] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every sample has been taken and every count word returned
  task automatic drain();
    while (!(n_accepted == n_pushed && tally_q.size() == 0)) @(posedge clk);
    repeat (3) @(posedge clk);
    n_phases++;
  endtask

  function automatic logic [COUNT_W-1:0] pick_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 75) return $urandom_range(1, 12);
    if (r < 90) return $urandom;
    return '1;
  endfunction

  initial begin
    logic [STAMP_IN_W-1:0] now;
    logic [PIN_W-1:0]      pins;
    logic [LIVE_W-1:0]     act;
    int unsigned           r;

    live_cfg = '0;
    for (int i = 0; i < OUT_COUNTS; i++) begin
      hold_ticks[i] = '0;
      seen_lvl[i]   = 1'b0;
      seen_stamp[i] = '0;
      steady_lvl[i] = 1'b0;
      edge_cnt[i]   = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no channels active after reset: everything reads zero
    push_sample('0, '1);
    push_sample('1, '0);
    drain();

    // all four channels, debounce off: raw level settles at once
    write_reg(CFG_ACTIVE_CHANNELS, 32'hFFFF_FFFC);
    push_sample(32'd1, 4'hF);
    push_sample(32'd2, 4'h0);
    push_sample(32'd3, 4'hF);
    push_sample(32'd4, 4'h5);
    push_sample(32'd5, 4'hA);
    drain();

    // saturating channel count, mixed hold times, stamps across the wrap
    write_reg(CFG_ACTIVE_CHANNELS, 32'd7);
    write_reg(CFG_STABLE_TICKS_0, 32'd3);
    write_reg(CFG_STABLE_TICKS_1, '1);
    write_reg(CFG_STABLE_TICKS_2, 32'd1);
    write_reg(CFG_STABLE_TICKS_3, '0);
    for (int k = CFG_FIRST_UNMAPPED; k <= int'(CFG_LAST_UNMAPPED); k++)
      write_reg(CFG_IDX_W'(k), '1);
    push_sample(32'hFFFF_FFFD, 4'hF);
    push_sample(32'hFFFF_FFFE, 4'hF);
    push_sample(32'h0000_0000, 4'hF);
    push_sample(32'h0000_0001, 4'hF);
    push_sample(32'h0000_0002, 4'h0);
    push_sample(32'h0000_0009, 4'h6);
    drain();

    // upper channels inactive: frozen and reading zero
    write_reg(CFG_ACTIVE_CHANNELS, 32'd2);
    push_sample(32'd10, 4'h0);
    push_sample(32'd11, 4'hF);
    push_sample(32'd20, 4'hF);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      r = $urandom_range(0, 99);
      act = (r < 60) ? LIVE_W'(OUT_COUNTS) : LIVE_W'($urandom_range(0, 7));
      if (ph == 0) act = '1;
      write_reg(CFG_ACTIVE_CHANNELS, {(CFG_DATA_W-LIVE_W)'($urandom), act});
      for (int ch = 0; ch < OUT_COUNTS; ch++)
        write_reg(CFG_STABLE_TICKS_0 + CFG_IDX_W'(ch),
                  (ph == 1) ? '1 : pick_ticks());
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, CFG_LAST_UNMAPPED)),
                  $urandom);
      flat_out = (ph % 4 == 1);
      now = ($urandom_range(0, 9) < 3) ? ('1 - $urandom_range(0, 60)) : $urandom;
      pins = PIN_W'($urandom);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          now = now + $urandom_range(0, 4);
          for (int ch = 0; ch < PIN_W; ch++)
            if ($urandom_range(0, 4) == 0) pins[ch] = !pins[ch];
        end else if (r < 95) begin
          now = now + 1'b1;
          pins = PIN_W'($urandom);
        end else begin
          now = $urandom;
        end
        push_sample(now, pins);
      end
      drain();
      flat_out = 1'b0;
    end

    if (tally_q.size() != 0)
      flag($sformatf("%0d count words never arrived", tally_q.size()));
    $display("covered %0d pin samples over %0d configuration phases", n_accepted,
             n_phases);
    $display("checked %0d count words, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("PASS debounced_pulse_counter_unit");
    end else begin
      $display("FAIL debounced_pulse_counter_unit");
    end
    $finish;
  end

endmodule
